/* hdl/tcp_stream_reassembly_table_defines.svh */
// Assertion macros used by the reassembly table controller.
`ifndef TCP_STREAM_REASSEMBLY_TABLE_DEFINES_SVH
`define TCP_STREAM_REASSEMBLY_TABLE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define TSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hdl/tsr_pkg.sv */
// ----------------------------------------------------------------------------
// Reassembly table package
// Sizes, request and status codes, and the controller command struct.
// ----------------------------------------------------------------------------
package tsr_pkg;
	localparam int Slots = 8;
	localparam int BufBytes = 4096;
	localparam int SlotW = $clog2(Slots);
	localparam int OffW = $clog2(BufBytes);
	localparam int AddrW = SlotW + OffW;
	localparam int LenW = OffW + 1;
	localparam int CntW = $clog2(Slots + 1);
	localparam logic [15:0] TtlReset = 16'd1000;

	localparam logic [2:0] ReqOpen = 3'd0;
	localparam logic [2:0] ReqData = 3'd1;
	localparam logic [2:0] ReqSeg = 3'd2;
	localparam logic [2:0] ReqTick = 3'd3;
	localparam logic [2:0] ReqRead = 3'd4;
	localparam logic [2:0] ReqRelease = 3'd5;

	localparam logic [2:0] StOk = 3'd0;
	localparam logic [2:0] StNoFree = 3'd1;
	localparam logic [2:0] StNoFlow = 3'd2;
	localparam logic [2:0] StWindow = 3'd3;
	localparam logic [2:0] StNoReady = 3'd4;

	typedef struct packed {
		logic exec;
		logic rd_finish;
		logic out_load;
	} tsr_cmd_t;

	typedef struct packed {
		logic rd_pending;
	} tsr_stat_t;
endpackage

/* hdl/tsr_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tsr_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wr_data,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		rd_data <= mem[addr];
	end
endmodule

/* hdl/tsr_ctrl.sv */
// ----------------------------------------------------------------------------
// Reassembly table controller
// Sequences each request through execute, optional buffer read and output.
// ----------------------------------------------------------------------------
`include "tcp_stream_reassembly_table_defines.svh"
module tsr_ctrl import tsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  tsr_stat_t stat,
	output tsr_cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_FULL = 3'b100
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = !(state_q == S_IDLE && out_free);

	always_comb begin
		cmd.exec = !in_stall && in_valid;
		cmd.rd_finish = state_q == S_READ && out_free;
		cmd.out_load = (cmd.exec && !stat.rd_pending) || cmd.rd_finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.exec && stat.rd_pending) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FULL: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TSR_ASSERT_IMPL(a_no_accept_in_read, clk, arst_n, state_q == S_READ, in_stall,
		"input accepted during buffer read")
	`TSR_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.out_load, out_valid,
		"loaded result not presented")
	`TSR_ASSERT_IMPL(a_one_load, clk, arst_n, cmd.rd_finish, !cmd.exec,
		"read completion overlaps a new request")
endmodule

/* hdl/tsr_datapath.sv */
// ----------------------------------------------------------------------------
// Reassembly table datapath
// Slot registers, match logic, payload buffer and the result register.
// ----------------------------------------------------------------------------
module tsr_datapath import tsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tsr_cmd_t          cmd,
	output tsr_stat_t         stat,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  logic [2:0]        req_type,
	input  logic [15:0]       port,
	input  logic [31:0]       sequence_req,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              fin,
	input  logic [11:0]       read_offset,
	output logic [2:0]        status,
	output logic [2:0]        slot_index,
	output logic              flow_ready,
	output logic [7:0]        read_data,
	output logic [12:0]       flow_length,
	output logic [3:0]        expired_count
);
	logic [15:0]     port_q [Slots];
	logic [31:0]     base_q [Slots];
	logic [15:0]     sum_q [Slots];
	logic [LenW-1:0] total_q [Slots];
	logic [LenW-1:0] pos_q [Slots];
	logic            done_q [Slots];
	logic [31:0]     born_q [Slots];
	logic [31:0]     tick_q;
	logic [15:0]     ttl_q;

	logic [Slots-1:0] m_free, m_open, m_ready, m_exp;
	logic             f_free, f_open, f_ready;
	logic [SlotW-1:0] i_free, i_open, i_ready;
	logic [31:0]      off;
	logic             in_win;
	logic [31:0]      tick_nx;

	logic [2:0]       r_status;
	logic [SlotW-1:0] r_slot;
	logic             r_ready;
	logic [LenW-1:0]  r_len;
	logic [CntW-1:0]  r_exp;
	logic             rd_go, wr_go;
	logic [AddrW-1:0] ram_addr;
	logic [7:0]       ram_q;
	logic [7:0]       read_data_q;

	logic [15:0]     n_sum;
	logic [LenW-1:0] n_pos, n_total;

	assign tick_nx = tick_q + 32'd1;

	always_comb begin
		for (int s = 0; s < Slots; s++) begin
			m_free[s] = port_q[s] == 16'd0 && !done_q[s];
			m_open[s] = !done_q[s] && port_q[s] == port;
			m_ready[s] = done_q[s] && port_q[s] != 16'd0;
			m_exp[s] = !done_q[s] && port_q[s] != 16'd0
				&& (tick_nx - born_q[s]) > {16'd0, ttl_q};
		end
		f_free = 1'b0; f_open = 1'b0; f_ready = 1'b0;
		i_free = '0; i_open = '0; i_ready = '0;
		for (int s = Slots - 1; s >= 0; s--) begin
			if (m_free[s]) begin f_free = 1'b1; i_free = SlotW'(s); end
			if (m_open[s]) begin f_open = 1'b1; i_open = SlotW'(s); end
			if (m_ready[s]) begin f_ready = 1'b1; i_ready = SlotW'(s); end
		end
		r_exp = '0;
		for (int s = 0; s < Slots; s++) begin
			r_exp = r_exp + CntW'(m_exp[s]);
		end
	end

	assign off = sequence_req - base_q[i_open];
	assign in_win = off < 32'(BufBytes);

	always_comb begin
		n_sum = sum_q[i_open];
		n_pos = pos_q[i_open];
		if (req_type == ReqData && in_win) begin
			if (n_sum != 16'hFFFF) begin
				n_sum = n_sum + 16'd1;
			end
			n_pos = LenW'(off) + LenW'(1);
		end
		n_total = total_q[i_open];
		if ((req_type == ReqSeg || last_byte) && fin) begin
			n_total = n_pos;
		end
	end

	always_comb begin
		r_status = StOk;
		r_slot = '0;
		r_ready = 1'b0;
		r_len = '0;
		rd_go = 1'b0;
		wr_go = 1'b0;
		case (req_type)
			ReqOpen: begin
				if (port == 16'd0) r_status = StNoFlow;
				else if (!f_free) r_status = StNoFree;
				else r_slot = i_free;
			end
			ReqData, ReqSeg: begin
				if (port == 16'd0 || !f_open) begin
					r_status = StNoFlow;
				end else begin
					if (req_type == ReqData) begin
						if (in_win) wr_go = 1'b1;
						else r_status = StWindow;
					end
					r_slot = i_open;
					r_ready = n_total != '0 && {3'd0, n_total} <= n_sum;
					r_len = n_total;
				end
			end
			ReqRead: begin
				if (!f_ready) begin
					r_status = StNoReady;
				end else begin
					r_slot = i_ready;
					r_ready = 1'b1;
					r_len = total_q[i_ready];
					if (LenW'(read_offset) < total_q[i_ready]) rd_go = 1'b1;
					else r_status = StWindow;
				end
			end
			ReqRelease: begin
				if (!f_ready) begin
					r_status = StNoReady;
				end else begin
					r_slot = i_ready;
					r_len = total_q[i_ready];
				end
			end
			default: r_status = StOk;
		endcase
	end

	assign stat.rd_pending = rd_go;

	always_comb begin
		if (req_type == ReqRead) ram_addr = {i_ready, read_offset};
		else ram_addr = {i_open, off[OffW-1:0]};
	end

	tsr_ram #(.Width(8), .Depth(Slots * BufBytes)) u_ram (
		.clk     (clk),
		.wr_en   (cmd.exec && wr_go),
		.addr    (ram_addr),
		.wr_data (data_byte),
		.rd_data (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < Slots; s++) begin
				port_q[s] <= '0; base_q[s] <= '0; sum_q[s] <= '0;
				total_q[s] <= '0; pos_q[s] <= '0; done_q[s] <= 1'b0;
				born_q[s] <= '0;
			end
			tick_q <= '0;
			ttl_q <= TtlReset;
		end else begin
			if (cfg_we) ttl_q <= cfg_data;
			if (cmd.exec) begin
				case (req_type)
					ReqOpen: begin
						if (port != 16'd0 && f_free) begin
							port_q[i_free] <= port;
							base_q[i_free] <= sequence_req + 32'd1;
							born_q[i_free] <= tick_q;
							sum_q[i_free] <= '0; total_q[i_free] <= '0;
							pos_q[i_free] <= '0; done_q[i_free] <= 1'b0;
						end
					end
					ReqData, ReqSeg: begin
						if (port != 16'd0 && f_open) begin
							sum_q[i_open] <= n_sum;
							pos_q[i_open] <= n_pos;
							total_q[i_open] <= n_total;
							done_q[i_open] <= r_ready;
						end
					end
					ReqTick: begin
						tick_q <= tick_nx;
						for (int s = 0; s < Slots; s++) begin
							if (m_exp[s]) begin
								port_q[s] <= '0; sum_q[s] <= '0; total_q[s] <= '0;
								pos_q[s] <= '0; done_q[s] <= 1'b0;
							end
						end
					end
					ReqRelease: begin
						if (f_ready) begin
							port_q[i_ready] <= '0; sum_q[i_ready] <= '0;
							total_q[i_ready] <= '0; pos_q[i_ready] <= '0;
							done_q[i_ready] <= 1'b0;
						end
					end
					default: tick_q <= tick_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status <= r_status;
			slot_index <= 3'(r_slot);
			flow_ready <= r_ready;
			flow_length <= 13'(r_len);
			expired_count <= (req_type == ReqTick) ? 4'(r_exp) : 4'd0;
		end
		if (cmd.rd_finish) read_data_q <= ram_q;
		else if (cmd.exec) read_data_q <= 8'd0;
	end

	assign read_data = read_data_q;
endmodule

/* hdl/tcp_stream_reassembly_table.sv */
// ----------------------------------------------------------------------------
// TCP stream reassembly table
// Eight receive flows keyed by port, with a 4 KiB payload window each.
// ----------------------------------------------------------------------------
// One request enters on the input channel (in_valid, in_stall) and produces
// exactly one result on the output channel (out_valid, out_stall). The result
// is registered: most requests present it in the cycle after acceptance. A
// new request is taken every cycle while the output register is free; a
// successful read passes the memory's registered read port and blocks input
// until its byte is loaded. The user must write the time-to-live register
// through cfg_valid and cfg_ready only while the block is idle; the block
// does not enforce this. Reset clears every slot, the tick counter and sets
// the time-to-live to 1000; the payload memory is not cleared and needs no
// pass. While the receiver stalls, the result holds and in_stall rises.
// ----------------------------------------------------------------------------
module tcp_stream_reassembly_table import tsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] port,
	input  logic [31:0] sequence_req,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        fin,
	input  logic [11:0] read_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [2:0]  slot_index,
	output logic        flow_ready,
	output logic [7:0]  read_data,
	output logic [12:0] flow_length,
	output logic [3:0]  expired_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	tsr_cmd_t  cmd;
	tsr_stat_t stat;

	assign cfg_ready = 1'b1;

	tsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tsr_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.port          (port),
		.sequence_req  (sequence_req),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.fin           (fin),
		.read_offset   (read_offset),
		.status        (status),
		.slot_index    (slot_index),
		.flow_ready    (flow_ready),
		.read_data     (read_data),
		.flow_length   (flow_length),
		.expired_count (expired_count)
	);
endmodule

/* tb/flow_table_checker.sv */
// ----------------------------------------------------------------------------
// Reassembly table checker
// Watches the request, result and configuration channels of the reassembly
// table, keeps its own copy of the flow table and payload windows, works out
// the result of every accepted request and compares each delivered result
// with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module flow_table_checker import tsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] port,
	input  logic [31:0] sequence_req,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        fin,
	input  logic [11:0] read_offset,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [2:0]  slot_index,
	input  logic        flow_ready,
	input  logic [7:0]  read_data,
	input  logic [12:0] flow_length,
	input  logic [3:0]  expired_count,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot;
		logic        ready;
		logic [7:0]  rdata;
		logic [12:0] length;
		logic [3:0]  expired;
	} flow_result_t;

	logic [15:0] ttl;
	logic [15:0] fl_port [Slots];
	logic [31:0] fl_base [Slots];
	logic [15:0] fl_sum [Slots];
	logic [12:0] fl_total [Slots];
	logic [12:0] fl_pos [Slots];
	logic        fl_done [Slots];
	logic [31:0] fl_born [Slots];
	logic [31:0] ticks;
	logic [7:0]  window [Slots * BufBytes];
	flow_result_t expected_results[$];

	function automatic int live_slot(logic [15:0] p);
		for (int s = 0; s < Slots; s++)
			if (!fl_done[s] && fl_port[s] == p)
				return s;
		return -1;
	endfunction

	function automatic int ready_slot();
		for (int s = 0; s < Slots; s++)
			if (fl_done[s] && fl_port[s] != 0)
				return s;
		return -1;
	endfunction

	function automatic void free_slot(int s);
		fl_port[s] = 0;
		fl_sum[s] = 0;
		fl_total[s] = 0;
		fl_pos[s] = 0;
		fl_done[s] = 0;
	endfunction

	function automatic flow_result_t predict_flow_result(logic [2:0] t, logic [15:0] p,
			logic [31:0] sq, logic [7:0] b, logic lst, logic f, logic [11:0] ro);
		flow_result_t r;
		int s;
		logic [31:0] off;
		r = '0;
		case (t)
			ReqOpen: begin
				if (p == 0) begin
					r.status = StNoFlow;
				end else begin
					s = live_slot(16'd0);
					if (s < 0) begin
						r.status = StNoFree;
					end else begin
						free_slot(s);
						fl_port[s] = p;
						fl_base[s] = sq + 32'd1;
						fl_born[s] = ticks;
						r.slot = s[2:0];
					end
				end
			end
			ReqData, ReqSeg: begin
				s = (p == 0) ? -1 : live_slot(p);
				if (s < 0) begin
					r.status = StNoFlow;
				end else begin
					if (t == ReqData) begin
						off = sq - fl_base[s];
						if (off < BufBytes) begin
							window[s * BufBytes + off] = b;
							if (fl_sum[s] != 16'hFFFF)
								fl_sum[s] = fl_sum[s] + 16'd1;
							fl_pos[s] = off[12:0] + 13'd1;
						end else begin
							r.status = StWindow;
						end
					end
					if ((t == ReqSeg || lst) && f)
						fl_total[s] = fl_pos[s];
					if (fl_total[s] != 0 && {3'd0, fl_total[s]} <= fl_sum[s])
						fl_done[s] = 1'b1;
					r.slot = s[2:0];
					r.ready = fl_done[s];
					r.length = fl_total[s];
				end
			end
			ReqTick: begin
				ticks = ticks + 32'd1;
				for (int i = 0; i < Slots; i++) begin
					if (!fl_done[i] && fl_port[i] != 0 && (ticks - fl_born[i]) > ttl) begin
						free_slot(i);
						r.expired = r.expired + 4'd1;
					end
				end
			end
			ReqRead: begin
				s = ready_slot();
				if (s < 0) begin
					r.status = StNoReady;
				end else begin
					r.slot = s[2:0];
					r.ready = 1'b1;
					r.length = fl_total[s];
					if ({1'b0, ro} < fl_total[s])
						r.rdata = window[s * BufBytes + ro];
					else
						r.status = StWindow;
				end
			end
			ReqRelease: begin
				s = ready_slot();
				if (s < 0) begin
					r.status = StNoReady;
				end else begin
					r.slot = s[2:0];
					r.length = fl_total[s];
					free_slot(s);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("%0t: %s mismatch, got %0d, expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		flow_result_t want;
		if (!arst_n) begin
			ttl = TtlReset;
			ticks = 0;
			for (int s = 0; s < Slots; s++) begin
				free_slot(s);
				fl_base[s] = 0;
				fl_born[s] = 0;
			end
			expected_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result delivered with no request outstanding", $realtime);
					errors++;
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (slot_index !== want.slot)
						report_mismatch("slot_index", slot_index, want.slot);
					if (flow_ready !== want.ready)
						report_mismatch("flow_ready", flow_ready, want.ready);
					if (read_data !== want.rdata)
						report_mismatch("read_data", read_data, want.rdata);
					if (flow_length !== want.length)
						report_mismatch("flow_length", flow_length, want.length);
					if (expired_count !== want.expired)
						report_mismatch("expired_count", expired_count, want.expired);
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(predict_flow_result(req_type, port,
					sequence_req, data_byte, last_byte, fin, read_offset));
			if (cfg_valid && cfg_ready)
				ttl = cfg_data;
		end
		pending = expected_results.size();
	end
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Reassembly table testbench
// Drives open, data, segment, tick, read and release requests into the
// reassembly table under three handshake profiles, rewrites the time-to-live
// between phases and leaves all result checking to the checker beside it.
// ----------------------------------------------------------------------------
module tb import tsr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 400000;
	localparam int RandomItems = 1140;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = '0;
	logic [15:0] port = '0;
	logic [31:0] sequence_req = '0;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        fin = 1'b0;
	logic [11:0] read_offset = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [2:0]  slot_index;
	logic        flow_ready;
	logic [7:0]  read_data;
	logic [12:0] flow_length;
	logic [3:0]  expired_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	int errors;
	int pending;
	int checked;
	int cycles = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	int sent = 0;
	int flows_started = 0;
	logic [15:0] fresh_port = 16'd100;

	tcp_stream_reassembly_table uut (.*);

	flow_table_checker checker_i (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < rx_idle);

	task automatic send_req(logic [2:0] t, logic [15:0] p, logic [31:0] sq,
			logic [7:0] b, logic lst, logic f, logic [11:0] ro);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		req_type <= t;
		port <= p;
		sequence_req <= sq;
		data_byte <= b;
		last_byte <= lst;
		fin <= f;
		read_offset <= ro;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic settle_then_write_ttl(logic [15:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_flow();
		logic [15:0] p;
		logic [31:0] base;
		int n;
		int order;
		int k;
		p = fresh_port;
		fresh_port++;
		flows_started++;
		base = $urandom;
		send_req(ReqOpen, p, base - 32'd1, 8'($urandom), 1'($urandom), 1'($urandom),
			12'($urandom));
		n = $urandom_range(1, 14);
		order = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			k = (order == 1) ? n - 1 - i : (order == 2) ? $urandom_range(0, n - 1) : i;
			if ($urandom_range(99) < 6)
				send_req(ReqData, p, base + ($urandom | 32'h1000), 8'($urandom), 1'b0,
					1'($urandom), 12'($urandom));
			send_req(ReqData, p, base + 32'(k), 8'($urandom), (i == n - 1) && order != 3,
				(i == n - 1) && order != 3 && $urandom_range(9) != 0, 12'($urandom));
		end
		if (order == 3)
			send_req(ReqSeg, p, $urandom, 8'($urandom), 1'($urandom),
				$urandom_range(9) != 0, 12'($urandom));
	endtask

	task automatic random_request();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			run_flow();
		else if (pick < 62)
			send_req(ReqRead, 16'($urandom), $urandom, 8'($urandom), 1'($urandom),
				1'($urandom), ($urandom_range(4) != 0) ? 12'($urandom_range(0, 70))
				: 12'($urandom_range(0, 4095)));
		else if (pick < 74)
			send_req(ReqRelease, 16'($urandom), $urandom, 8'($urandom), 1'($urandom),
				1'($urandom), 12'($urandom));
		else if (pick < 84)
			send_req(ReqTick, 16'($urandom), $urandom, 8'($urandom), 1'($urandom),
				1'($urandom), 12'($urandom));
		else if (pick < 88)
			send_req(3'($urandom_range(6, 7)), 16'($urandom), $urandom, 8'($urandom),
				1'($urandom), 1'($urandom), 12'($urandom));
		else if (pick < 92)
			send_req(3'($urandom_range(ReqOpen, ReqSeg)), 16'd0, $urandom, 8'($urandom),
				1'($urandom), 1'($urandom), 12'($urandom));
		else
			send_req(3'($urandom_range(ReqData, ReqSeg)), 16'($urandom_range(60000, 65534)),
				$urandom, 8'($urandom), 1'($urandom), 1'($urandom), 12'($urandom));
	endtask

	task automatic clear_table();
		settle_then_write_ttl(16'd1);
		repeat (3) send_req(ReqTick, 0, 0, 0, 0, 0, 0);
		repeat (Slots) send_req(ReqRelease, 0, 0, 0, 0, 0, 0);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_req(ReqRead, 0, 0, 0, 0, 0, 0);
		send_req(ReqRelease, 0, 0, 0, 0, 0, 0);
		send_req(ReqOpen, 16'd0, 32'd5, 0, 0, 0, 0);
		send_req(ReqData, 16'd0, 32'd6, 8'hFF, 1'b1, 1'b1, 0);
		send_req(ReqSeg, 16'd0, 0, 0, 0, 1'b1, 0);
		send_req(3'd6, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 12'hFFF);
		send_req(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 12'hFFF);
		send_req(ReqData, 16'd5, 32'd1, 8'd1, 1'b1, 1'b1, 0);

		// Every slot gets its first 64 bytes written, so later reads stay on written data.
		for (int s = 0; s < Slots; s++)
			send_req(ReqOpen, 16'(10 + s), 32'hFFFF_FFFF, 0, 0, 0, 0);
		for (int s = 0; s < Slots; s++) begin
			for (int k = 0; k < 64; k++)
				send_req(ReqData, 16'(10 + s), 32'(k), 8'($urandom), k == 63, k == 63, 0);
		end
		send_req(ReqRead, 0, 0, 0, 0, 0, 12'd63);
		send_req(ReqRead, 0, 0, 0, 0, 0, 12'd64);
		send_req(ReqRead, 0, 0, 0, 0, 0, 12'hFFF);
		repeat (Slots + 1) send_req(ReqRelease, 0, 0, 0, 0, 0, 0);

		settle_then_write_ttl(16'd65535);
		for (int s = 0; s < Slots + 1; s++)
			send_req(ReqOpen, 16'(20 + s), 32'd999, 0, 0, 0, 0);
		send_req(ReqData, 16'd20, 32'd1000 + 32'd4095, 8'hFF, 1'b1, 1'b1, 0);
		send_req(ReqData, 16'd21, 32'd999, 8'h00, 1'b1, 1'b1, 0);
		send_req(ReqSeg, 16'd22, 0, 0, 0, 1'b0, 0);
		send_req(ReqTick, 0, 0, 0, 0, 0, 0);
		settle_then_write_ttl(16'd1);
		send_req(ReqTick, 0, 0, 0, 0, 0, 0);
		send_req(ReqTick, 0, 0, 0, 0, 0, 0);

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle = (phase == 0) ? 29 : (phase == 1) ? 82 : 0;
			rx_idle = (phase == 0) ? 82 : (phase == 1) ? 29 : 0;
			if (phase == 2)
				clear_table();
			settle_then_write_ttl(16'($urandom_range(20, 200)));
			sent = 0;
			while (sent < RandomItems / 3)
				random_request();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		$display("Checked %0d results; %0d random flows under three handshake profiles,",
			checked, flows_started);
		$display("plus window edges, a full table and eight-flow expiry.");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hdl
hdl/tsr_pkg.sv
hdl/tsr_ram.sv
hdl/tsr_ctrl.sv
hdl/tsr_datapath.sv
hdl/tcp_stream_reassembly_table.sv
tb/flow_table_checker.sv
tb/tb.sv
